/* src/rcbc_pkg.sv */
// Shared types, codes and command pattern tables for the relay command and button controller.
package rcbc_pkg;

    localparam int ADDR_W     = 48;
    localparam int DEB_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int PAT_COUNT  = 9;
    localparam int PAT_MAXLEN = 12;
    localparam int IDX_W      = 4;
    localparam int PAT_BITS   = PAT_MAXLEN * 8;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam logic [PAT_COUNT-1:0] PAT_ALL = '1;
    localparam logic [DEB_W-1:0] QUIET_MAX = '1;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd3;

    // Queue depth shared by the command queue and the result queue.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;

    // Reply codes.
    localparam logic [2:0] REPLY_NONE = 3'd0;
    localparam logic [2:0] REPLY_ACK  = 3'd1;
    localparam logic [2:0] REPLY_ON   = 3'd2;
    localparam logic [2:0] REPLY_OFF  = 3'd3;
    localparam logic [2:0] REPLY_BAD  = 3'd4;

    // Operations passed from the front to the back.
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE   = 3'd0;
    localparam op_t OP_BUTTON = 3'd1;
    localparam op_t OP_HELLO  = 3'd2;
    localparam op_t OP_ON     = 3'd3;
    localparam op_t OP_OFF    = 3'd4;
    localparam op_t OP_TOGGLE = 3'd5;
    localparam op_t OP_STATUS = 3'd6;
    localparam op_t OP_BAD    = 3'd7;

    typedef struct packed {
        logic              action;
        logic              button_pressed;
        logic [7:0]        msg_byte;
        logic              first_byte;
        logic              last_byte;
        logic [ADDR_W-1:0] source_addr;
    } item_t;

    typedef struct packed {
        logic       relay_on;
        logic [2:0] reply_code;
        logic       notify_event;
    } result_t;

    // Command strings, left-justified and zero padded to the longest pattern.
    localparam logic [PAT_BITS-1:0] PAT_HOLA      = {"hola",         64'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELE_ON   = {"rele on",      40'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELAY_ON  = {"relay on",     32'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELE_OFF  = {"rele off",     32'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELAY_OFF = {"relay off",    24'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELE_TGL  = {"rele toggle",  8'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELAY_TGL = "relay toggle";
    localparam logic [PAT_BITS-1:0] PAT_RELE_ST   = {"rele status",  8'h0};
    localparam logic [PAT_BITS-1:0] PAT_RELAY_ST  = "relay status";

    function automatic logic [7:0] pat_char(input logic [3:0] p, input logic [IDX_W-1:0] i);
        logic [PAT_BITS-1:0] text;
        logic [PAT_BITS-1:0] shifted;
        case (p)
            4'd0:    text = PAT_HOLA;
            4'd1:    text = PAT_RELE_ON;
            4'd2:    text = PAT_RELAY_ON;
            4'd3:    text = PAT_RELE_OFF;
            4'd4:    text = PAT_RELAY_OFF;
            4'd5:    text = PAT_RELE_TGL;
            4'd6:    text = PAT_RELAY_TGL;
            4'd7:    text = PAT_RELE_ST;
            4'd8:    text = PAT_RELAY_ST;
            default: text = '0;
        endcase
        shifted = text << {i, 3'b000};
        return shifted[PAT_BITS-1 -: 8];
    endfunction

    function automatic logic [IDX_W-1:0] pat_len(input logic [3:0] p);
        logic [IDX_W-1:0] len;
        case (p)
            4'd0:    len = 4'd4;
            4'd1:    len = 4'd7;
            4'd2:    len = 4'd8;
            4'd3:    len = 4'd8;
            4'd4:    len = 4'd9;
            4'd5:    len = 4'd11;
            4'd6:    len = 4'd12;
            4'd7:    len = 4'd11;
            4'd8:    len = 4'd12;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic op_t pat_op(input logic [3:0] p);
        op_t op;
        case (p)
            4'd0:          op = OP_HELLO;
            4'd1, 4'd2:    op = OP_ON;
            4'd3, 4'd4:    op = OP_OFF;
            4'd5, 4'd6:    op = OP_TOGGLE;
            4'd7, 4'd8:    op = OP_STATUS;
            default:       op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

/* src/rcbc_front.sv */
// Front end: configuration registers, button debounce and per-byte command matching.
module rcbc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rcbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcbc_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          take,
    input  rcbc_pkg::item_t               item,
    output rcbc_pkg::op_t                 op
);
    import rcbc_pkg::*;

    logic [ADDR_W-1:0]    peer_a_reg;
    logic [ADDR_W-1:0]    peer_b_reg;
    logic [DEB_W-1:0]     debounce_reg;

    logic                 last_button_reg, last_button_next;
    logic                 stable_button_reg, stable_button_next;
    logic [DEB_W-1:0]     quiet_polls_reg, quiet_polls_next;
    logic [IDX_W-1:0]     byte_index_reg, byte_index_next;
    logic [PAT_COUNT-1:0] match_mask_reg, match_mask_next;
    logic                 sender_ok_reg, sender_ok_next;

    logic [IDX_W-1:0]     idx;
    logic [PAT_COUNT-1:0] mask_base;
    logic [PAT_COUNT-1:0] mask_hit;
    logic                 sok;
    logic                 found;
    op_t                  found_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_a_reg   <= '0;
            peer_b_reg   <= '0;
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PEER_A:   peer_a_reg   <= cfg_wdata;
                CFG_PEER_B:   peer_b_reg   <= cfg_wdata;
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata[DEB_W-1:0];
                default:      ;
            endcase
        end
    end

    // Message position, running match set and sender check for this byte.
    always_comb
    begin
        idx       = item.first_byte ? '0 : byte_index_reg;
        mask_base = item.first_byte ? PAT_ALL : match_mask_reg;
        sok       = item.first_byte ? ((item.source_addr == peer_a_reg) ||
                                       (item.source_addr == peer_b_reg))
                                    : sender_ok_reg;
        for (int p = 0; p < PAT_COUNT; p++)
        begin
            mask_hit[p] = mask_base[p] && (idx < pat_len(4'(p))) &&
                          (pat_char(4'(p), idx) == item.msg_byte);
        end
        found    = 1'b0;
        found_op = OP_BAD;
        for (int p = PAT_COUNT - 1; p >= 0; p--)
        begin
            if (mask_hit[p] && ({1'b0, pat_len(4'(p))} == ({1'b0, idx} + 5'd1)))
            begin
                found    = 1'b1;
                found_op = pat_op(4'(p));
            end
        end
    end

    always_comb
    begin
        last_button_next   = last_button_reg;
        stable_button_next = stable_button_reg;
        quiet_polls_next   = quiet_polls_reg;
        byte_index_next    = byte_index_reg;
        match_mask_next    = match_mask_reg;
        sender_ok_next     = sender_ok_reg;
        op                 = OP_NONE;

        if (!item.action)
        begin
            // Poll tick: restart the quiet count on a change, else count up.
            if (item.button_pressed != last_button_reg)
            begin
                last_button_next = item.button_pressed;
                quiet_polls_next = '0;
            end
            else if (quiet_polls_reg != QUIET_MAX)
            begin
                quiet_polls_next = quiet_polls_reg + 1'b1;
            end
            if ((item.button_pressed != stable_button_reg) &&
                (quiet_polls_next >= debounce_reg))
            begin
                stable_button_next = item.button_pressed;
                if (item.button_pressed)
                    op = OP_BUTTON;
            end
        end
        else if (!item.last_byte)
        begin
            byte_index_next = (idx < IDX_MAX) ? idx + 1'b1 : idx;
            match_mask_next = mask_hit;
            sender_ok_next  = sok;
        end
        else
        begin
            // Final byte: close the message and, if the sender passed the check, classify it.
            byte_index_next = '0;
            match_mask_next = PAT_ALL;
            sender_ok_next  = 1'b0;
            if (sok)
                op = found ? found_op : OP_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_button_reg   <= 1'b0;
            stable_button_reg <= 1'b0;
            quiet_polls_reg   <= '0;
            byte_index_reg    <= '0;
            match_mask_reg    <= PAT_ALL;
            sender_ok_reg     <= 1'b0;
        end
        else if (take)
        begin
            last_button_reg   <= last_button_next;
            stable_button_reg <= stable_button_next;
            quiet_polls_reg   <= quiet_polls_next;
            byte_index_reg    <= byte_index_next;
            match_mask_reg    <= match_mask_next;
            sender_ok_reg     <= sender_ok_next;
        end
    end

endmodule

/* src/rcbc_cmd_fifo.sv */
// Short operation queue between the front end and the back end.
module rcbc_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rcbc_pkg::op_t wr_op,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output rcbc_pkg::op_t rd_op
);
    import rcbc_pkg::*;

    op_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (!wr_en && rd_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* src/rcbc_back.sv */
// Back end: relay state, reply generation and the result queue.
module rcbc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  rcbc_pkg::op_t     op,
    output logic              op_take,
    output logic              empty,
    input  logic              pop,
    output rcbc_pkg::result_t result
);
    import rcbc_pkg::*;

    logic               relay_reg, relay_next;
    result_t            res_next;
    result_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               rd_en;

    assign op_take = op_valid && (count_reg != Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_en   = pop && !empty;
    assign result  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        relay_next            = relay_reg;
        res_next.reply_code   = REPLY_NONE;
        res_next.notify_event = 1'b0;
        case (op)
            OP_BUTTON:
            begin
                relay_next            = !relay_reg;
                res_next.notify_event = 1'b1;
            end
            OP_HELLO:  res_next.reply_code = REPLY_ACK;
            OP_ON:
            begin
                relay_next            = 1'b1;
                res_next.notify_event = 1'b1;
                res_next.reply_code   = REPLY_ON;
            end
            OP_OFF:
            begin
                relay_next            = 1'b0;
                res_next.notify_event = 1'b1;
                res_next.reply_code   = REPLY_OFF;
            end
            OP_TOGGLE:
            begin
                relay_next            = !relay_reg;
                res_next.notify_event = 1'b1;
                res_next.reply_code   = relay_reg ? REPLY_OFF : REPLY_ON;
            end
            OP_STATUS: res_next.reply_code = relay_reg ? REPLY_ON : REPLY_OFF;
            OP_BAD:    res_next.reply_code = REPLY_BAD;
            default:   ;
        endcase
        res_next.relay_on = relay_next;
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
            mem_reg[wr_ptr_reg] <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (op_take)
            begin
                relay_reg  <= relay_next;
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (op_take && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (!op_take && rd_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* src/relay_command_and_button_controller_core.sv */
// Top level of the relay command and button controller.
//
// The block drives one relay bit from two sources. Each input word is either a
// poll tick carrying a button sample (debounced: a new level must hold for
// debounce_polls ticks, and a new pressed level toggles the relay) or one byte
// of a text command from a sender address. A message counts only if its first
// byte came from peer_addr_a or peer_addr_b and the whole message equals one
// of the nine command strings. Every input word yields exactly one result word:
// the relay level after it, a reply code and a notify flag. The block takes one
// word per cycle while the operation queue has room, and keeps that rate only
// while results are popped; a word passes through the front end into the
// operation queue, then through the back end into the result queue. The front
// end holds the debounce counters and the per-byte match set, comparing each
// byte against all patterns at once; the back end owns the relay level. A
// two-entry queue on each side lets the front keep accepting while results
// wait to be popped. Write configuration only while the block is idle.
module relay_command_and_button_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rcbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcbc_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  rcbc_pkg::item_t                item,
    output logic                           empty,
    input  logic                           pop,
    output rcbc_pkg::result_t              result
);
    import rcbc_pkg::*;

    logic take;
    op_t  front_op;
    logic q_valid;
    op_t  q_op;
    logic q_take;

    // Accept a word whenever the operation queue has room.
    assign take = push && !full;

    rcbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (item),
        .op        (front_op)
    );

    // Hold classified operations until the back end has result space.
    rcbc_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take),
        .wr_op    (front_op),
        .full     (full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_op    (q_op)
    );

    rcbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_op),
        .op_take  (q_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

/* sim/tb_relay_command_and_button_controller_core.sv */
// Self-checking testbench for the relay command and button controller core.
module tb_relay_command_and_button_controller_core;
    import rcbc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_CMDS      = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_CAP     = 100;
    // Index 3 decodes to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {CMD_GREET, CMD_SET_ON, CMD_SET_OFF, CMD_FLIP, CMD_QUERY} cmd_kind_t;
    typedef logic [7:0] byte_q_t[$];

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 push      = 1'b0;
    logic                 full;
    item_t                item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    result_t              result;

    relay_command_and_button_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Command strings and what each one does, in table order.
    string cmd_text [NUM_CMDS] = '{"hola", "rele on", "relay on", "rele off", "relay off",
                                   "rele toggle", "relay toggle", "rele status", "relay status"};
    cmd_kind_t cmd_kind [NUM_CMDS] = '{CMD_GREET, CMD_SET_ON, CMD_SET_ON, CMD_SET_OFF,
                                       CMD_SET_OFF, CMD_FLIP, CMD_FLIP, CMD_QUERY, CMD_QUERY};

    // Predictor copy of the registers and state, at their reset values.
    logic [ADDR_W-1:0]    peer_a     = '0;
    logic [ADDR_W-1:0]    peer_b     = '0;
    logic [DEB_W-1:0]     deb_polls  = DEBOUNCE_RESET;
    logic                 relay_lvl  = 1'b0;
    logic                 btn_last   = 1'b0;
    logic                 btn_stable = 1'b0;
    logic [DEB_W-1:0]     quiet_cnt  = '0;
    logic [IDX_W-1:0]     msg_pos    = '0;
    logic [NUM_CMDS-1:0]  msg_match  = '1;
    logic                 msg_auth   = 1'b0;

    result_t     relay_results_due[$];
    int unsigned cycle_cnt   = 0;
    int unsigned fail_cnt    = 0;
    int unsigned words_sent  = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          poll_mix_pct = 0;

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // Watchdog: a hung handshake or a lost result word ends here.
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("relay_command_and_button_controller_core regression: fail");
        $finish;
    end

    // Advance the predictor by one accepted input word and return the result word it owes.
    function automatic result_t next_relay_result(input item_t w);
        result_t r;
        int      p;
        int      hit;
        r   = '0;
        hit = -1;
        if (!w.action)
        begin
            // Debounce: a changed sample restarts the quiet count.
            if (w.button_pressed != btn_last)
            begin
                btn_last  = w.button_pressed;
                quiet_cnt = '0;
            end
            else if (quiet_cnt != QUIET_MAX)
            begin
                quiet_cnt = quiet_cnt + 1'b1;
            end
            if (w.button_pressed != btn_stable && quiet_cnt >= deb_polls)
            begin
                btn_stable = w.button_pressed;
                if (w.button_pressed)
                begin
                    relay_lvl      = ~relay_lvl;
                    r.notify_event = 1'b1;
                end
            end
        end
        else
        begin
            // A first byte drops any open message and latches the sender check.
            if (w.first_byte)
            begin
                msg_pos   = '0;
                msg_match = '1;
                msg_auth  = (w.source_addr == peer_a) || (w.source_addr == peer_b);
            end
            for (p = 0; p < NUM_CMDS; p++)
            begin
                if (msg_pos >= cmd_text[p].len() || cmd_text[p][msg_pos] != w.msg_byte)
                    msg_match[p] = 1'b0;
            end
            if (!w.last_byte)
            begin
                if (msg_pos != IDX_MAX)
                    msg_pos = msg_pos + 1'b1;
            end
            else
            begin
                // The whole length must match, so pick the pattern ending here.
                for (p = 0; p < NUM_CMDS; p++)
                begin
                    if (hit < 0 && msg_match[p] && cmd_text[p].len() == int'(msg_pos) + 1)
                        hit = p;
                end
                if (msg_auth)
                begin
                    if (hit < 0)
                    begin
                        r.reply_code = REPLY_BAD;
                    end
                    else
                    begin
                        case (cmd_kind[hit])
                            CMD_GREET:
                            begin
                                r.reply_code = REPLY_ACK;
                            end
                            CMD_SET_ON:
                            begin
                                relay_lvl      = 1'b1;
                                r.notify_event = 1'b1;
                                r.reply_code   = REPLY_ON;
                            end
                            CMD_SET_OFF:
                            begin
                                relay_lvl      = 1'b0;
                                r.notify_event = 1'b1;
                                r.reply_code   = REPLY_OFF;
                            end
                            CMD_FLIP:
                            begin
                                relay_lvl      = ~relay_lvl;
                                r.notify_event = 1'b1;
                                r.reply_code   = relay_lvl ? REPLY_ON : REPLY_OFF;
                            end
                            default:
                            begin
                                r.reply_code = relay_lvl ? REPLY_ON : REPLY_OFF;
                            end
                        endcase
                    end
                end
                msg_pos   = '0;
                msg_match = '1;
                msg_auth  = 1'b0;
            end
        end
        r.relay_on = relay_lvl;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_cnt++;
            if (fail_cnt <= PRINT_CAP)
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Compare every popped result word with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && empty === 1'b0)
        begin
            if (relay_results_due.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= PRINT_CAP)
                    $display("%0t: unexpected result word: expected none actual %h",
                             $time, result);
            end
            else
            begin
                want = relay_results_due.pop_front();
                check_field("relay_on", int'(want.relay_on), int'(result.relay_on));
                check_field("reply_code", int'(want.reply_code), int'(result.reply_code));
                check_field("notify_event", int'(want.notify_event),
                            int'(result.notify_event));
            end
        end
    end

    // Receiver side: stall pop at the current rate.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_sender();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return peer_a;
        if (k < 85)
            return peer_b;
        return rand_addr();
    endfunction

    // Poll tick; the message fields are don't-care and get random values.
    function automatic item_t poll_word(input logic pressed);
        logic [63:0] v;
        item_t       w;
        v = {$urandom(), $urandom()};
        w = v[$bits(item_t)-1:0];
        w.action         = 1'b0;
        w.button_pressed = pressed;
        return w;
    endfunction

    function automatic item_t byte_word(input logic [7:0] b, input logic first,
                                        input logic last, input logic [ADDR_W-1:0] src);
        item_t w;
        w.action         = 1'b1;
        w.button_pressed = 1'($urandom_range(1));
        w.msg_byte       = b;
        w.first_byte     = first;
        w.last_byte      = last;
        w.source_addr    = src;
        return w;
    endfunction

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        int      i;
        for (i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Offer one word, hold it until accepted, then log its prediction.
    // Entered and left just after a falling edge.
    task automatic push_word(input item_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        relay_results_due.push_back(next_relay_result(w));
        words_sent++;
        @(negedge clk);
    endtask

    // Stream a message; open and close select the first and last markers.
    task automatic send_text(input byte_q_t msg, input logic [ADDR_W-1:0] src,
                             input logic open, input logic close);
        int i;
        for (i = 0; i < msg.size(); i++)
        begin
            if (i > 0 && $urandom_range(99) < poll_mix_pct)
                push_word(poll_word(1'($urandom_range(1))));
            push_word(byte_word(msg[i], open && i == 0, close && i == msg.size() - 1,
                                i == 0 ? src : rand_addr()));
        end
    endtask

    // Drop push and wait for every owed result word plus the pipeline depth.
    task automatic settle();
        push <= 1'b0;
        while (relay_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_PEER_A:   peer_a    = data;
            CFG_PEER_B:   peer_b    = data;
            CFG_DEBOUNCE: deb_polls = data[DEB_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
    endtask

    // Reprogram all registers on an idle block; junk rides in the unused upper bits.
    task automatic load_settings(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                 input logic [DEB_W-1:0] deb);
        logic [ADDR_W-1:0] junk;
        settle();
        junk = rand_addr();
        write_reg(CFG_PEER_A, a);
        write_reg(CFG_PEER_B, b);
        write_reg(CFG_DEBOUNCE, {junk[ADDR_W-1:DEB_W], deb});
        write_reg(CFG_UNUSED, rand_addr());
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int send_idle, input int recv_stall);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
    endtask

    // Registers still at reset: both peers are address zero, debounce is three.
    task automatic test_reset_defaults();
        send_text(to_bytes("hola"), '0, 1'b1, 1'b1);
        repeat (5) push_word(poll_word(1'b1));
        repeat (5) push_word(poll_word(1'b0));
    endtask

    // Every command once, then sender, framing and length corner cases.
    task automatic test_commands();
        byte_q_t odd;
        int      p;
        load_settings(rand_addr(), rand_addr(), DEBOUNCE_RESET);
        for (p = 0; p < NUM_CMDS; p++)
            send_text(to_bytes(cmd_text[p]), p[0] ? peer_b : peer_a, 1'b1, 1'b1);
        // status with the relay on
        send_text(to_bytes("relay on"), peer_b, 1'b1, 1'b1);
        send_text(to_bytes("rele status"), peer_a, 1'b1, 1'b1);
        // stranger: no reply, no change
        send_text(to_bytes("relay toggle"), ~peer_a, 1'b1, 1'b1);
        // headless bytes belong to no authorized message
        send_text(to_bytes("relay off"), peer_a, 1'b0, 1'b1);
        // an open message is dropped by the next first byte
        send_text(to_bytes("relay of"), peer_a, 1'b1, 1'b0);
        send_text(to_bytes("hola"), peer_b, 1'b1, 1'b1);
        // prefix and overlong
        send_text(to_bytes("rele o"), peer_a, 1'b1, 1'b1);
        send_text(to_bytes("relay status xyzwv"), peer_b, 1'b1, 1'b1);
        // single-byte messages at the byte extremes
        odd.push_back(8'h00);
        send_text(odd, peer_a, 1'b1, 1'b1);
        odd[0] = 8'hFF;
        send_text(odd, peer_b, 1'b1, 1'b1);
    endtask

    // Debounce at zero, one and the maximum, including quiet count saturation.
    task automatic test_debounce();
        load_settings(peer_a, peer_b, '0);
        repeat (3)
        begin
            push_word(poll_word(1'b1));
            push_word(poll_word(1'b0));
        end
        load_settings(peer_a, peer_b, 8'd1);
        repeat (2) push_word(poll_word(1'b1));
        repeat (2) push_word(poll_word(1'b0));
        push_word(poll_word(1'b1));
        push_word(poll_word(1'b0));
        load_settings(peer_a, peer_b, '1);
        repeat (300) push_word(poll_word(1'b1));
        push_word(poll_word(1'b0));
        repeat (10) push_word(poll_word(1'b1));
        repeat (260) push_word(poll_word(1'b0));
    endtask

    // Runs of button levels with occasional bounce.
    task automatic button_burst();
        int   runs;
        int   len;
        logic lvl;
        runs = $urandom_range(1, 4);
        repeat (runs)
        begin
            lvl = 1'($urandom_range(1));
            len = $urandom_range(1, int'(deb_polls) + 3);
            repeat (len) push_word(poll_word(($urandom_range(99) < 10) ? ~lvl : lvl));
        end
    endtask

    // Mostly real commands; the rest corrupted, cut, stretched, replaced, headless or dropped.
    task automatic random_message();
        byte_q_t           msg;
        logic [ADDR_W-1:0] src;
        int                k;
        int                cut;
        msg = to_bytes(cmd_text[$urandom_range(NUM_CMDS - 1)]);
        src = pick_sender();
        k   = $urandom_range(99);
        if (k < 10)
        begin
            msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
        end
        else if (k < 16)
        begin
            cut = $urandom_range(1, msg.size() - 1);
            msg = msg[0:cut-1];
        end
        else if (k < 22)
        begin
            repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
        end
        else if (k < 28)
        begin
            msg.delete();
            repeat ($urandom_range(1, 14)) msg.push_back(8'($urandom_range(255)));
        end
        if (k >= 28 && k < 34)
        begin
            send_text(msg, src, 1'b1, 1'b0);
            send_text(to_bytes(cmd_text[$urandom_range(NUM_CMDS - 1)]), pick_sender(),
                      1'b1, 1'b1);
        end
        else if (k >= 34 && k < 39)
        begin
            send_text(msg, src, 1'b0, 1'b1);
        end
        else
        begin
            send_text(msg, src, 1'b1, 1'b1);
        end
    endtask

    task automatic run_traffic(input int n_words);
        int unsigned stop;
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            if ($urandom_range(99) < 25)
                button_burst();
            else
                random_message();
        end
    endtask

    // Four idling phases, two register settings each, peers at the extremes twice.
    task automatic test_random_traffic();
        int ph;
        int blk;
        poll_mix_pct = 5;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(52, 0);
                2:       set_idling(0, 52);
                default: set_idling(13, 13);
            endcase
            for (blk = 0; blk < 2; blk++)
            begin
                if (ph == 1 && blk == 0)
                    load_settings('0, '1, 8'($urandom_range(0, 5)));
                else if (ph == 2 && blk == 1)
                    load_settings('1, '0, 8'($urandom_range(0, 5)));
                else
                    load_settings(rand_addr(), rand_addr(), 8'($urandom_range(0, 5)));
                run_traffic(125);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_idling(0, 52);
        test_reset_defaults();
        set_idling(13, 13);
        test_commands();
        set_idling(52, 0);
        test_debounce();
        test_random_traffic();
        settle();
        if (fail_cnt == 0)
            $display("relay_command_and_button_controller_core regression: pass");
        else
            $display("relay_command_and_button_controller_core regression: fail");
        $finish;
    end

endmodule
